[hdl/mfps_pkg.sv]
// Shared types and constants for the metaball field pixel shader.
// No dependencies; used by every module of the block.
package mfps_pkg;

    // Request codes carried on s_req_type.
    localparam logic [1:0] REQ_PIXEL   = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_PALETTE = 2'd2;
    localparam logic [1:0] REQ_BALL    = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // Fixed field widths.
    localparam int SPEED_W  = 7;
    localparam int WEIGHT_W = 16;
    localparam int LEVEL_W  = 8;
    localparam int RGB_W    = 24;
    localparam int FRAME_W  = 11;
    localparam int POS_W    = 10;
    localparam int Q_W      = 17;

    // Saturated field level and reset frame size.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 8'd255;
    localparam logic [FRAME_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [FRAME_W-1:0] HEIGHT_RESET = 11'd480;

endpackage

[hdl/metaball_field_pixel_shader_unit.sv]
// Top level of the metaball field pixel shader: ball table, palette and sequencer.
// Depends on mfps_pkg and mfps_inv_dist.
//
//  channel | direction | transaction
//  s_      | in        | pixel query, frame tick, palette write or ball load
//  m_      | out       | field level and palette color of one pixel query
//  cfg_    | in        | frame width / height write
//
// A pixel query visits each ball in turn; for each ball the bit-serial inverse
// distance unit produces its result one bit a cycle.
// A ball that sits exactly on the pixel ends the query early with the top level.
// A frame tick handles each ball with one table read and one write back.
// Palette writes and ball loads complete in the cycle they are accepted.
// Reset is synchronous and clears the ball table through per-entry valid bits.
// A finished result waits in the output register while new transactions are taken.
module metaball_field_pixel_shader_unit #(
    parameter int BALL_COUNT = 10,
    parameter int COORD_BITS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_index,
    input  logic [mfps_pkg::FRAME_W-1:0]      cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic [mfps_pkg::POS_W-1:0]        s_pos_x,
    input  logic [mfps_pkg::POS_W-1:0]        s_pos_y,
    input  logic [7:0]                        s_entry_index,
    input  logic [mfps_pkg::RGB_W-1:0]        s_color_word,
    input  logic signed [mfps_pkg::SPEED_W-1:0] s_step_x,
    input  logic signed [mfps_pkg::SPEED_W-1:0] s_step_y,
    input  logic [mfps_pkg::WEIGHT_W-1:0]     s_ball_weight,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mfps_pkg::LEVEL_W-1:0]      m_field_level,
    output logic [mfps_pkg::RGB_W-1:0]        m_pixel_rgb
);
    localparam int CW  = COORD_BITS;
    localparam int IW  = (BALL_COUNT > 1) ? $clog2(BALL_COUNT) : 1;
    localparam int D2W = 2 * CW + 1;
    localparam int LW  = (CW + 3 > mfps_pkg::FRAME_W + 1) ? CW + 3 : mfps_pkg::FRAME_W + 1;
    localparam logic [IW-1:0] LAST_BALL = IW'(BALL_COUNT - 1);
    localparam logic [LW-1:0] COORD_SPAN = LW'(1) << CW;

    // Sequencer state codes.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_P_RD  = 4'd1;
    localparam logic [3:0] ST_P_DIF = 4'd2;
    localparam logic [3:0] ST_P_SQ  = 4'd3;
    localparam logic [3:0] ST_P_D2  = 4'd4;
    localparam logic [3:0] ST_P_INV = 4'd5;
    localparam logic [3:0] ST_P_MUL = 4'd6;
    localparam logic [3:0] ST_P_ACC = 4'd7;
    localparam logic [3:0] ST_P_PAL = 4'd8;
    localparam logic [3:0] ST_P_OUT = 4'd9;
    localparam logic [3:0] ST_T_RD  = 4'd10;
    localparam logic [3:0] ST_T_WR  = 4'd11;
    localparam logic [3:0] ST_P_SUM = 4'd12;

    typedef struct packed {
        logic [CW-1:0]                        x;
        logic [CW-1:0]                        y;
        logic signed [mfps_pkg::SPEED_W-1:0]  sx;
        logic signed [mfps_pkg::SPEED_W-1:0]  sy;
        logic [mfps_pkg::WEIGHT_W-1:0]        w;
    } ball_t;

    logic [3:0]   state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [mfps_pkg::FRAME_W-1:0] width_reg, height_reg;
    logic s_fire;

    // Ball table memory with per-entry valid bits.
    ball_t ball_mem [BALL_COUNT];
    logic [BALL_COUNT-1:0] ball_vld_reg;
    ball_t ball_rd_reg;
    logic  ball_rd_vld_reg;
    ball_t ball_cur;
    logic  ball_we;
    logic [IW-1:0] ball_waddr;
    ball_t ball_wdata;

    // Palette memory.
    logic [mfps_pkg::RGB_W-1:0] pal_mem [256];
    logic [mfps_pkg::RGB_W-1:0] pal_rd_reg;

    // Pixel datapath registers.
    logic [CW-1:0] px_reg, py_reg;
    logic signed [CW:0] dx_reg, dy_reg;
    logic [2*CW-1:0] sqx_reg, sqy_reg;
    logic [D2W-1:0]  d2_reg;
    logic [12:0]     contrib_reg;
    logic [mfps_pkg::LEVEL_W-1:0] sum_reg, sum_next;
    logic [13:0]     sum_wide;

    // Output register.
    logic m_valid_reg;
    logic [mfps_pkg::LEVEL_W-1:0] m_level_reg;
    logic [mfps_pkg::RGB_W-1:0]   m_rgb_reg;
    logic out_load;

    // Inverse distance unit handshake.
    logic inv_start, inv_done;
    logic [mfps_pkg::Q_W-1:0] inv_q;
    logic [2*mfps_pkg::Q_W-2:0] prod;

    // Coordinate width adaptation.
    logic [CW+mfps_pkg::POS_W-1:0] pos_x_ext, pos_y_ext;
    logic [CW-1:0] in_x, in_y;

    // Ball movement.
    logic [LW-1:0] lim_x, lim_y, nx_u, ny_u;
    logic signed [CW+1:0] nx, ny;
    logic bounce_x, bounce_y;
    ball_t moved;

    assign s_fire    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign pos_x_ext = {{CW{1'b0}}, s_pos_x};
    assign pos_y_ext = {{CW{1'b0}}, s_pos_y};
    assign in_x      = pos_x_ext[CW-1:0];
    assign in_y      = pos_y_ext[CW-1:0];
    assign ball_cur  = ball_rd_vld_reg ? ball_rd_reg : '0;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mfps_pkg::WIDTH_RESET;
            height_reg <= mfps_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                mfps_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_wr_data;
                mfps_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Bounce limits and next positions for a frame tick.
    always_comb begin
        lim_x = (LW'(width_reg) > COORD_SPAN) ? COORD_SPAN : LW'(width_reg);
        lim_y = (LW'(height_reg) > COORD_SPAN) ? COORD_SPAN : LW'(height_reg);
        nx = signed'((CW + 2)'(ball_cur.x)) + (CW + 2)'(ball_cur.sx);
        ny = signed'((CW + 2)'(ball_cur.y)) + (CW + 2)'(ball_cur.sy);
        nx_u = LW'(unsigned'(nx));
        ny_u = LW'(unsigned'(ny));
        bounce_x = nx[CW+1] || (nx_u >= lim_x);
        bounce_y = ny[CW+1] || (ny_u >= lim_y);
        moved = ball_cur;
        if (bounce_x) begin
            moved.sx = -ball_cur.sx;
        end else begin
            moved.x = nx[CW-1:0];
        end
        if (bounce_y) begin
            moved.sy = -ball_cur.sy;
        end else begin
            moved.y = ny[CW-1:0];
        end
    end

    // Ball table write port: load on accept, write back during a tick.
    always_comb begin
        ball_we    = 1'b0;
        ball_waddr = idx_reg;
        ball_wdata = moved;
        if (state_reg == ST_T_WR) begin
            ball_we = 1'b1;
        end else if (s_fire && s_req_type == mfps_pkg::REQ_BALL
                     && s_entry_index < 8'(BALL_COUNT)) begin
            ball_we    = 1'b1;
            ball_waddr = s_entry_index[IW-1:0];
            ball_wdata = '{x: in_x, y: in_y, sx: s_step_x, sy: s_step_y, w: s_ball_weight};
        end
    end

    always_ff @(posedge aclk) begin
        if (ball_we) begin
            ball_mem[ball_waddr] <= ball_wdata;
        end
        ball_rd_reg <= ball_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ball_vld_reg    <= '0;
            ball_rd_vld_reg <= 1'b0;
        end else begin
            if (ball_we) begin
                ball_vld_reg[ball_waddr] <= 1'b1;
            end
            ball_rd_vld_reg <= ball_vld_reg[idx_reg];
        end
    end

    // Palette memory: written on accept, read at the running sum.
    always_ff @(posedge aclk) begin
        if (s_fire && s_req_type == mfps_pkg::REQ_PALETTE) begin
            pal_mem[s_entry_index] <= s_color_word;
        end
        pal_rd_reg <= pal_mem[sum_reg];
    end

    // Field datapath.
    assign prod     = ball_cur.w * inv_q;
    assign sum_wide = 14'(sum_reg) + 14'(contrib_reg);

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
        dx_reg  <= signed'((CW + 1)'(px_reg)) - signed'((CW + 1)'(ball_cur.x));
        dy_reg  <= signed'((CW + 1)'(py_reg)) - signed'((CW + 1)'(ball_cur.y));
        sqx_reg <= unsigned'((2 * CW)'(dx_reg) * (2 * CW)'(dx_reg));
        sqy_reg <= unsigned'((2 * CW)'(dy_reg) * (2 * CW)'(dy_reg));
        d2_reg  <= D2W'(sqx_reg) + D2W'(sqy_reg);
        contrib_reg <= prod[32:20];
    end

    mfps_inv_dist #(
        .D2W(D2W)
    ) u_inv_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (inv_start),
        .d2      (d2_reg),
        .done    (inv_done),
        .q       (inv_q)
    );

    assign out_load = !m_valid_reg || m_ready;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        inv_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_req_type == mfps_pkg::REQ_PIXEL) begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = ST_P_RD;
                end else if (s_fire && s_req_type == mfps_pkg::REQ_TICK) begin
                    idx_next   = '0;
                    state_next = ST_T_RD;
                end
            end
            ST_P_RD:  state_next = ST_P_DIF;
            ST_P_DIF: state_next = ST_P_SQ;
            ST_P_SQ:  state_next = ST_P_SUM;
            ST_P_SUM: state_next = ST_P_D2;
            ST_P_D2: begin
                if (d2_reg == '0) begin
                    sum_next   = mfps_pkg::LEVEL_MAX;
                    state_next = ST_P_PAL;
                end else begin
                    inv_start  = 1'b1;
                    state_next = ST_P_INV;
                end
            end
            ST_P_INV: begin
                if (inv_done) begin
                    state_next = ST_P_MUL;
                end
            end
            ST_P_MUL: state_next = ST_P_ACC;
            ST_P_ACC: begin
                if (contrib_reg >= 13'(mfps_pkg::LEVEL_MAX)
                    || sum_wide >= 14'(mfps_pkg::LEVEL_MAX)) begin
                    sum_next = mfps_pkg::LEVEL_MAX;
                end else begin
                    sum_next = sum_wide[mfps_pkg::LEVEL_W-1:0];
                end
                if (idx_reg == LAST_BALL) begin
                    state_next = ST_P_PAL;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_P_RD;
                end
            end
            ST_P_PAL: state_next = ST_P_OUT;
            ST_P_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            ST_T_RD:  state_next = ST_T_WR;
            ST_T_WR: begin
                if (idx_reg == LAST_BALL) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_T_RD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            sum_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_P_OUT && out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (state_reg == ST_P_OUT && out_load) begin
            m_level_reg <= sum_reg;
            m_rgb_reg   <= pal_rd_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_field_level = m_level_reg;
    assign m_pixel_rgb   = m_rgb_reg;
endmodule

[hdl/mfps_inv_dist.sv]
// Iterative rounded inverse distance: largest q with (2q-1)^2 * d2 <= 2^34.
// Depends on mfps_pkg for the result width.
module mfps_inv_dist #(
    parameter int D2W = 21
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [D2W-1:0]            d2,
    output logic                      done,
    output logic [mfps_pkg::Q_W-1:0]  q
);
    localparam int AW = D2W + 37;
    localparam logic signed [AW-1:0] LIMIT = AW'(64'd1 << 34);

    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [AW-1:0] bs_reg, bs_next;
    logic signed [AW-1:0] ds_reg, ds_next;
    logic [mfps_pkg::Q_W-1:0] bit_reg, bit_next;
    logic [mfps_pkg::Q_W-1:0] q_reg, q_next;
    logic done_reg, done_next;
    logic signed [AW-1:0] trial;
    logic                 take;
    logic signed [AW-1:0] d2_ext;

    // One result bit per cycle; acc holds t^2*d2, bs holds t*d2 scaled, ds d2 scaled.
    always_comb begin
        d2_ext   = signed'(AW'(d2));
        trial    = acc_reg + bs_reg + ds_reg;
        take     = (trial <= LIMIT);
        acc_next = acc_reg;
        bs_next  = bs_reg;
        ds_next  = ds_reg;
        bit_next = bit_reg;
        q_next   = q_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next = d2_ext;
            bs_next  = -(d2_ext <<< 18);
            ds_next  = d2_ext <<< 34;
            bit_next = {1'b1, {(mfps_pkg::Q_W-1){1'b0}}};
            q_next   = '0;
        end else if (|bit_reg) begin
            if (take) begin
                acc_next = trial;
                q_next   = q_reg | bit_reg;
                bs_next  = (bs_reg + (ds_reg <<< 1)) >>> 1;
            end else begin
                bs_next  = bs_reg >>> 1;
            end
            ds_next   = ds_reg >>> 2;
            bit_next  = bit_reg >> 1;
            done_next = bit_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            bit_reg  <= bit_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        bs_reg  <= bs_next;
        ds_reg  <= ds_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;
endmodule

[hdl/mfps_checker.sv]
// Port-level checks for the metaball field pixel shader, bound to the top level.
// Depends on mfps_pkg and metaball_field_pixel_shader_unit.
module mfps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_req_type,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_field_level,
    input logic [23:0] m_pixel_rgb
);
    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_field_level) && $stable(m_pixel_rgb))
        else $error("result changed while stalled");

    // No result is shown right after reset.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Queries and ticks keep the sequencer busy, so s_ready is low in the cycle after acceptance.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == mfps_pkg::REQ_PIXEL
            || s_req_type == mfps_pkg::REQ_TICK) |=> !s_ready)
        else $error("input accepted during a multi-cycle transaction");

    // The handshake outputs always carry known values out of reset.
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown(s_ready) && !$isunknown(m_valid))
        else $error("handshake output unknown");
endmodule

bind metaball_field_pixel_shader_unit mfps_checker u_mfps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_req_type    (s_req_type),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_field_level (m_field_level),
    .m_pixel_rgb   (m_pixel_rgb)
);

[sim/tb_metaball_field_pixel_shader_unit.sv]
// Self-checking testbench for metaball_field_pixel_shader_unit: directed, random and stall tests.
// Depends on mfps_pkg and the block's RTL; keeps its own copy of the ball table and palette.
module tb_metaball_field_pixel_shader_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBALLS      = 10;
    localparam int IDLE_CYCLES = 300;
    localparam int CYCLE_LIMIT = 3000000;

    // Field widths taken from the package.
    localparam int LEVEL_W  = mfps_pkg::LEVEL_W;
    localparam int RGB_W    = mfps_pkg::RGB_W;
    localparam int FRAME_W  = mfps_pkg::FRAME_W;
    localparam int POS_W    = mfps_pkg::POS_W;
    localparam int SPEED_W  = mfps_pkg::SPEED_W;
    localparam int WEIGHT_W = mfps_pkg::WEIGHT_W;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [RGB_W-1:0]   rgb;
    } shade_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_index = mfps_pkg::CFG_FRAME_WIDTH;
    logic [FRAME_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = mfps_pkg::REQ_TICK;
    logic [POS_W-1:0] s_pos_x = '0;
    logic [POS_W-1:0] s_pos_y = '0;
    logic [7:0] s_entry_index = '0;
    logic [RGB_W-1:0] s_color_word = '0;
    logic signed [SPEED_W-1:0] s_step_x = '0;
    logic signed [SPEED_W-1:0] s_step_y = '0;
    logic [WEIGHT_W-1:0] s_ball_weight = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [LEVEL_W-1:0] m_field_level;
    logic [RGB_W-1:0] m_pixel_rgb;

    // Shadow state of the block.
    logic [FRAME_W-1:0] width_reg = mfps_pkg::WIDTH_RESET;
    logic [FRAME_W-1:0] height_reg = mfps_pkg::HEIGHT_RESET;
    logic [POS_W-1:0] bx [NBALLS];
    logic [POS_W-1:0] by [NBALLS];
    logic signed [SPEED_W-1:0] vx [NBALLS];
    logic signed [SPEED_W-1:0] vy [NBALLS];
    logic [WEIGHT_W-1:0] bw [NBALLS];
    logic [RGB_W-1:0] palette [256];
    bit pal_written [256];

    shade_t pending_shades[$];
    int errors = 0;
    int cycles = 0;
    int queries_sent = 0;
    int results_seen = 0;
    bit quiet = 1'b0;
    int hold_off = 0;

    metaball_field_pixel_shader_unit DUT (.*);

    // Clock with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Round-half-up of 65536 / sqrt(d2), found by binary search.
    function automatic longint unsigned recip_dist(longint unsigned d2);
        longint unsigned lo, hi, mid, t;
        lo = 1;
        hi = 65536;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * d2 <= (64'd1 << 34)) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // Saturated field sum at one pixel over the shadow ball table.
    function automatic logic [LEVEL_W-1:0] field_sum(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
        longint dx, dy;
        longint unsigned d2, c, sum;
        sum = 0;
        for (int i = 0; i < NBALLS; i++) begin
            dx = longint'(px) - longint'(bx[i]);
            dy = longint'(py) - longint'(by[i]);
            d2 = dx * dx + dy * dy;
            if (d2 == 0) return mfps_pkg::LEVEL_MAX;
            c = (longint'(bw[i]) * recip_dist(d2)) >> 20;
            if (c >= 255 || sum + c >= 255) sum = 255;
            else sum += c;
        end
        return sum[LEVEL_W-1:0];
    endfunction

    // One axis of a frame tick: step inside the limit or reverse the speed.
    task automatic move_axis(ref logic [POS_W-1:0] p, ref logic signed [SPEED_W-1:0] v,
                             input logic [FRAME_W-1:0] lim_reg);
        int lim, n;
        lim = (lim_reg > 1024) ? 1024 : int'(lim_reg);
        n = int'(p) + int'(v);
        if (n < 0 || n >= lim) v = -v;
        else p = n[POS_W-1:0];
    endtask

    // Update the shadow state for an accepted transaction and queue any result.
    task automatic predict_item(logic [1:0] kind, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                logic [7:0] idx, logic [RGB_W-1:0] color,
                                logic signed [SPEED_W-1:0] sx, logic signed [SPEED_W-1:0] sy,
                                logic [WEIGHT_W-1:0] w);
        shade_t s;
        case (kind)
            mfps_pkg::REQ_PIXEL: begin
                s.level = field_sum(x, y);
                s.rgb = palette[s.level];
                pending_shades.push_back(s);
                queries_sent++;
            end
            mfps_pkg::REQ_TICK: begin
                for (int i = 0; i < NBALLS; i++) begin
                    move_axis(bx[i], vx[i], width_reg);
                    move_axis(by[i], vy[i], height_reg);
                end
            end
            mfps_pkg::REQ_PALETTE: begin
                palette[idx] = color;
                pal_written[idx] = 1'b1;
            end
            mfps_pkg::REQ_BALL: begin
                if (idx < NBALLS) begin
                    bx[idx] = x;
                    by[idx] = y;
                    vx[idx] = sx;
                    vy[idx] = sy;
                    bw[idx] = w;
                end
            end
        endcase
    endtask

    // Drive one transaction, wait for acceptance, then predict it.
    task automatic send_raw(logic [1:0] kind, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                            logic [7:0] idx, logic [RGB_W-1:0] color,
                            logic signed [SPEED_W-1:0] sx, logic signed [SPEED_W-1:0] sy,
                            logic [WEIGHT_W-1:0] w);
        int gap;
        gap = (!quiet && $urandom_range(7) == 0) ? $urandom_range(19, 1) : 0;
        if (gap > 0) begin
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_req_type <= kind;
        s_pos_x <= x;
        s_pos_y <= y;
        s_entry_index <= idx;
        s_color_word <= color;
        s_step_x <= sx;
        s_step_y <= sy;
        s_ball_weight <= w;
        s_valid <= 1'b1;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        predict_item(kind, x, y, idx, color, sx, sy, w);
    endtask

    // A pixel query whose palette entry is always defined beforehand.
    task automatic send_pixel(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
        logic [LEVEL_W-1:0] lvl;
        lvl = field_sum(x, y);
        if (!pal_written[lvl])
            send_raw(mfps_pkg::REQ_PALETTE, POS_W'($urandom), POS_W'($urandom), lvl,
                     RGB_W'($urandom), SPEED_W'($urandom), SPEED_W'($urandom),
                     WEIGHT_W'($urandom));
        send_raw(mfps_pkg::REQ_PIXEL, x, y, 8'($urandom), RGB_W'($urandom),
                 SPEED_W'($urandom), SPEED_W'($urandom), WEIGHT_W'($urandom));
    endtask

    task automatic send_ball(logic [7:0] idx, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic signed [SPEED_W-1:0] sx, logic signed [SPEED_W-1:0] sy,
                             logic [WEIGHT_W-1:0] w);
        send_raw(mfps_pkg::REQ_BALL, x, y, idx, RGB_W'($urandom), sx, sy, w);
    endtask

    // Wait until no result is outstanding.
    task automatic drain();
        while (pending_shades.size() != 0) @(posedge aclk);
    endtask

    // Wait until the block is idle, then write one frame register.
    task automatic write_frame(logic index, logic [FRAME_W-1:0] value);
        @(negedge aclk) s_valid <= 1'b0;
        drain();
        repeat (IDLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_index <= index;
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(negedge aclk) cfg_wr_en <= 1'b0;
        if (index == mfps_pkg::CFG_FRAME_WIDTH) width_reg = value;
        else height_reg = value;
    endtask

    function automatic logic signed [SPEED_W-1:0] rand_speed();
        return SPEED_W'($urandom_range(126) - 63);
    endfunction

    // Result receiver with random stalls and an optional long hold-off.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                hold_off--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(9) == 0) begin
                stall = $urandom_range(19, 1) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        shade_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_shades.size() == 0) begin
                $error("unexpected result: field_level %0d pixel_rgb %06h",
                       m_field_level, m_pixel_rgb);
                errors++;
            end else begin
                e = pending_shades.pop_front();
                if (m_field_level !== e.level) begin
                    $error("field_level expected %0d actual %0d", e.level, m_field_level);
                    errors++;
                end
                if (m_pixel_rgb !== e.rgb) begin
                    $error("pixel_rgb expected %06h actual %06h", e.rgb, m_pixel_rgb);
                    errors++;
                end
            end
        end
    end

    // Field extremes, distance zero, ignored ball numbers and bounces.
    task automatic test_directed();
        send_raw(mfps_pkg::REQ_PALETTE, '0, '0, 8'd0, 24'h000000, '0, '0, '0);
        send_raw(mfps_pkg::REQ_PALETTE, '0, '0, 8'd255, 24'hFFFFFF, '0, '0, '0);
        send_pixel(10'd0, 10'd0);
        send_ball(8'd0, 10'd0, 10'd0, 7'sd63, -7'sd63, 16'hFFFF);
        send_ball(8'd9, 10'd1023, 10'd1023, -7'sd63, 7'sd63, 16'h0001);
        send_ball(8'd5, 10'd512, 10'd300, 7'sd1, 7'sd0, 16'h8000);
        send_ball(8'd200, 10'd7, 10'd7, 7'sd5, 7'sd5, 16'hFFFF);
        send_ball(8'd10, 10'd9, 10'd9, 7'sd5, 7'sd5, 16'hFFFF);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd7, 10'd7);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd512, 10'd301);
        send_raw(mfps_pkg::REQ_TICK, '0, '0, '0, '0, '0, '0, '0);
        send_pixel(10'd63, 10'd0);
        send_raw(mfps_pkg::REQ_TICK, '0, '0, '0, '0, '0, '0, '0);
        send_pixel(10'd512, 10'd300);
        send_pixel(10'd600, 10'd400);
    endtask

    // Random traffic at one frame size: mostly queries, many near a ball, plus ticks, palette writes and loads.
    task automatic test_random(int n_items);
        int k, b;
        for (int i = 0; i < n_items; i++) begin
            k = $urandom_range(99);
            b = $urandom_range(NBALLS - 1);
            if (k < 45) begin
                if ($urandom_range(3) == 0) send_pixel(POS_W'($urandom), POS_W'($urandom));
                else send_pixel(POS_W'(bx[b] + $urandom_range(40) - 20),
                                POS_W'(by[b] + $urandom_range(40) - 20));
            end else if (k < 65) send_raw(mfps_pkg::REQ_TICK, POS_W'($urandom),
                                          POS_W'($urandom), 8'($urandom), RGB_W'($urandom),
                                          SPEED_W'($urandom), SPEED_W'($urandom),
                                          WEIGHT_W'($urandom));
            else if (k < 80) send_raw(mfps_pkg::REQ_PALETTE, POS_W'($urandom),
                                      POS_W'($urandom), 8'($urandom), RGB_W'($urandom),
                                      SPEED_W'($urandom), SPEED_W'($urandom),
                                      WEIGHT_W'($urandom));
            else if (k < 97) send_ball(8'(b), POS_W'($urandom), POS_W'($urandom), rand_speed(),
                                       rand_speed(), WEIGHT_W'($urandom));
            else send_ball(8'($urandom_range(255, NBALLS)), POS_W'($urandom), POS_W'($urandom),
                           rand_speed(), rand_speed(), WEIGHT_W'($urandom));
        end
    endtask

    // Hold the result side off while queries keep coming, so the input stalls.
    task automatic test_backpressure();
        hold_off = 4000;
        for (int i = 0; i < 24; i++) send_pixel(POS_W'($urandom), POS_W'($urandom));
    endtask

    initial begin
        for (int i = 0; i < NBALLS; i++) begin
            bx[i] = '0; by[i] = '0; vx[i] = '0; vy[i] = '0; bw[i] = '0;
        end
        for (int i = 0; i < 256; i++) begin
            palette[i] = '0;
            pal_written[i] = 1'b0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        test_directed();
        write_frame(mfps_pkg::CFG_FRAME_WIDTH, 11'd1);
        write_frame(mfps_pkg::CFG_FRAME_HEIGHT, 11'd1024);
        test_random(250);
        write_frame(mfps_pkg::CFG_FRAME_WIDTH, 11'd2047);
        write_frame(mfps_pkg::CFG_FRAME_HEIGHT, 11'd0);
        test_random(250);
        test_backpressure();
        write_frame(mfps_pkg::CFG_FRAME_WIDTH, 11'd1024);
        write_frame(mfps_pkg::CFG_FRAME_HEIGHT, 11'd1);
        test_random(250);
        write_frame(mfps_pkg::CFG_FRAME_WIDTH, 11'd97);
        write_frame(mfps_pkg::CFG_FRAME_HEIGHT, 11'd2047);
        test_random(250);
        write_frame(mfps_pkg::CFG_FRAME_WIDTH, 11'd640);
        write_frame(mfps_pkg::CFG_FRAME_HEIGHT, 11'd480);
        quiet = 1'b1;
        test_random(250);

        @(negedge aclk) s_valid <= 1'b0;
        drain();
        repeat (IDLE_CYCLES) @(posedge aclk);
        $display("Covered %0d pixel queries (%0d results checked) with ball loads, ticks,",
                 queries_sent, results_seen);
        $display("palette writes, several frame sizes and a long result-side stall.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
